// ===== sv/kvts_pkg.sv =====
// kvts_pkg: shared types and default sizes for the key-value table store
// no dependencies; imported by kvts_store, kvts_seq and key_value_table_store_core
`default_nettype none

package kvts_pkg;

  // default geometry
  localparam int KVTS_ENTRIES    = 16;
  localparam int KVTS_KEY_BITS   = 64;
  localparam int KVTS_VALUE_BITS = 64;

  // width of the key, value and read_value ports
  localparam int KVTS_FIELD_BITS = 64;

  // unused code is a no-op
  typedef enum logic [1:0] {
    CMD_PUT = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_ACT,
    S_RESP
  } state_e;

  // operations the sequencer asks of the entry store in one cycle
  typedef struct packed {
    logic key_rd;    // read key memory at rd_addr
    logic val_rd;    // read value memory at rd_addr
    logic wr_entry;  // write key and value at wr_addr, set valid
    logic wr_value;  // write value only at wr_addr
    logic clr_valid; // clear valid at wr_addr
  } store_op_t;

endpackage

`default_nettype wire

// ===== sv/key_value_table_store_core.sv =====
// key_value_table_store_core: top level of the associative key-value table
// depends on kvts_pkg, kvts_store and kvts_seq
`default_nettype none

// A small associative key-value table. Raise start_i with command_i
// (0 put, 1 get, 2 delete), key_i and value_i while busy_o is low; the beat
// is taken on that edge and busy_o rises until the result is out. Each
// command gives exactly one result beat: done_o is high for a single cycle
// with found_o, read_value_o, status_o (0 done, 1 key absent, 2 table full)
// and entry_count_o, and the receiver cannot hold it off, so it must take
// the beat in that cycle. The block takes no new beat before it is through
// with the last one: one comparator walks the key memory, which has a
// single read port, one entry per cycle, then the last compare finishes,
// the write or value read is applied and the result is presented; the
// block then returns to idle, and the next beat can only be taken once
// it is back in idle. Only the low KEY_BITS of the key and the low
// VALUE_BITS of the value take part. A put with an unknown key takes the
// lowest free entry. Code 3 is a no-op that reports found 0, status done
// and the unchanged count. The valid bits reset to empty; no clearing pass
// is needed.
module key_value_table_store_core #(
  parameter int ENTRIES    = kvts_pkg::KVTS_ENTRIES,
  parameter int KEY_BITS   = kvts_pkg::KVTS_KEY_BITS,
  parameter int VALUE_BITS = kvts_pkg::KVTS_VALUE_BITS,
  localparam int CntW      = $clog2(ENTRIES + 1)
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  output logic                                 busy_o,
  input  wire  [1:0]                           command_i,
  input  wire  [kvts_pkg::KVTS_FIELD_BITS-1:0] key_i,
  input  wire  [kvts_pkg::KVTS_FIELD_BITS-1:0] value_i,
  output logic                                 done_o,
  output logic                                 found_o,
  output logic [kvts_pkg::KVTS_FIELD_BITS-1:0] read_value_o,
  output logic [1:0]                           status_o,
  output logic [CntW-1:0]                      entry_count_o
);
  import kvts_pkg::*;

  localparam int IdxW = $clog2(ENTRIES);

  // sequencer to store
  store_op_t             op;
  logic [IdxW-1:0]       rd_addr, wr_addr;
  logic [KEY_BITS-1:0]   wr_key, key_rd;
  logic [VALUE_BITS-1:0] wr_val, val_rd;
  logic [ENTRIES-1:0]    valid;

  // control: scan, compare, apply, respond
  kvts_seq #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .found_o       (found_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .op_o          (op),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .wr_key_o      (wr_key),
    .wr_val_o      (wr_val),
    .key_rd_i      (key_rd),
    .val_rd_i      (val_rd),
    .valid_i       (valid)
  );

  // entry storage: key and value memories, valid flops
  kvts_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_val_i  (wr_val),
    .key_rd_o  (key_rd),
    .val_rd_o  (val_rd),
    .valid_o   (valid)
  );

endmodule

`default_nettype wire

// ===== sv/kvts_store.sv =====
// kvts_store: key and value memories with registered reads, plus per-entry valid flops
// depends on kvts_pkg
`default_nettype none

module kvts_store #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  localparam int IdxW      = $clog2(ENTRIES)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  kvts_pkg::store_op_t     op_i,
  input  wire  [IdxW-1:0]         rd_addr_i,
  input  wire  [IdxW-1:0]         wr_addr_i,
  input  wire  [KEY_BITS-1:0]     wr_key_i,
  input  wire  [VALUE_BITS-1:0]   wr_val_i,
  output logic [KEY_BITS-1:0]     key_rd_o,
  output logic [VALUE_BITS-1:0]   val_rd_o,
  output logic [ENTRIES-1:0]      valid_o
);
  import kvts_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;

  // key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (op_i.wr_entry) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (op_i.key_rd) begin
      key_rd_o <= key_mem[rd_addr_i];
    end
  end

  // value memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (op_i.wr_entry || op_i.wr_value) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
    if (op_i.val_rd) begin
      val_rd_o <= val_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (op_i.wr_entry) begin
      valid_q[wr_addr_i] <= 1'b1;
    end else if (op_i.clr_valid) begin
      valid_q[wr_addr_i] <= 1'b0;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== sv/kvts_seq.sv =====
// kvts_seq: command sequencer with the shared key comparator, free-slot tracker and count
// depends on kvts_pkg; drives kvts_store
`default_nettype none

module kvts_seq #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  localparam int IdxW      = $clog2(ENTRIES),
  localparam int CntW      = $clog2(ENTRIES + 1)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire  [1:0]                        command_i,
  input  wire  [kvts_pkg::KVTS_FIELD_BITS-1:0] key_i,
  input  wire  [kvts_pkg::KVTS_FIELD_BITS-1:0] value_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic                              found_o,
  output logic [kvts_pkg::KVTS_FIELD_BITS-1:0] read_value_o,
  output logic [1:0]                        status_o,
  output logic [CntW-1:0]                   entry_count_o,
  output kvts_pkg::store_op_t               op_o,
  output logic [IdxW-1:0]                   rd_addr_o,
  output logic [IdxW-1:0]                   wr_addr_o,
  output logic [KEY_BITS-1:0]               wr_key_o,
  output logic [VALUE_BITS-1:0]             wr_val_o,
  input  wire  [KEY_BITS-1:0]               key_rd_i,
  input  wire  [VALUE_BITS-1:0]             val_rd_i,
  input  wire  [ENTRIES-1:0]                valid_i
);
  import kvts_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(ENTRIES);

  state_e state_q, state_d;

  logic                  accept;
  cmd_e                  cmd_q;
  logic                  cmd_ok_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [IdxW-1:0] scan_idx_q;
  logic            cmp_en_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            hit_q, free_found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic            cmp_hit, cmp_free;

  logic [CntW-1:0] count_q;
  logic            found_q, get_hit_q;
  status_e         status_q;

  assign accept = start_i && (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_SCAN;
      S_SCAN: if (scan_idx_q == LastIdx) state_d = S_LAST;
      S_LAST: state_d = S_ACT;
      S_ACT:  state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // store requests
  always_comb begin
    op_o      = '0;
    rd_addr_o = scan_idx_q;
    wr_addr_o = hit_idx_q;
    wr_key_o  = key_q;
    wr_val_o  = val_q;
    unique case (state_q)
      S_SCAN: op_o.key_rd = 1'b1;
      S_ACT: begin
        rd_addr_o = hit_idx_q;
        if (cmd_ok_q) begin
          unique case (cmd_q)
            CMD_PUT: begin
              if (hit_q) begin
                op_o.wr_value = 1'b1;
              end else if (free_found_q) begin
                op_o.wr_entry = 1'b1;
                wr_addr_o     = free_idx_q;
              end
            end
            CMD_GET: op_o.val_rd    = hit_q;
            CMD_DEL: op_o.clr_valid = hit_q;
            default: op_o = '0;
          endcase
        end
      end
      default: op_o = '0;
    endcase
  end

  // shared comparator works on the entry read in the previous cycle
  assign cmp_hit  = cmp_en_q && valid_i[cmp_idx_q] && (key_rd_i == key_q);
  assign cmp_free = cmp_en_q && !valid_i[cmp_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      cmp_en_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      cmp_en_q <= (state_q == S_SCAN);
      if (accept) begin
        scan_idx_q   <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (state_q == S_SCAN) begin
          scan_idx_q <= scan_idx_q + IdxW'(1);
        end
        if (cmp_hit && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (cmp_free && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_ok_q <= (command_i != CMD_NOP);
      cmd_q    <= cmd_e'(command_i);
      key_q    <= key_i[KEY_BITS-1:0];
      val_q    <= value_i[VALUE_BITS-1:0];
    end
    cmp_idx_q <= scan_idx_q;
    if (cmp_hit && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (cmp_free && !free_found_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // result and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      found_q   <= 1'b0;
      get_hit_q <= 1'b0;
      status_q  <= ST_DONE;
    end else if (state_q == S_ACT) begin
      found_q   <= cmd_ok_q && hit_q;
      get_hit_q <= cmd_ok_q && hit_q && (cmd_q == CMD_GET);
      status_q  <= ST_DONE;
      if (cmd_ok_q) begin
        unique case (cmd_q)
          CMD_PUT: begin
            if (!hit_q) begin
              if (free_found_q) begin
                count_q <= count_q + CntW'(1);
              end else begin
                status_q <= ST_FULL;
              end
            end
          end
          CMD_GET: if (!hit_q) status_q <= ST_ABSENT;
          CMD_DEL: begin
            if (!hit_q) begin
              status_q <= ST_ABSENT;
            end else if (count_q != '0) begin
              count_q <= count_q - CntW'(1);
            end
          end
          default: status_q <= ST_DONE;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    busy_o        = (state_q != S_IDLE);
    done_o        = (state_q == S_RESP);
    found_o       = found_q;
    status_o      = status_q;
    entry_count_o = count_q;
    read_value_o  = get_hit_q ? KVTS_FIELD_BITS'(val_rd_i) : '0;
  end

  // an accepted command always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("kvts_seq: accepted command did not start");

  // occupancy tracks the valid bits whenever the table is at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (count_q == CntW'($countones(valid_i))))
    else $error("kvts_seq: occupancy out of step with valid bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("kvts_seq: occupancy above table size");

  // a full table report never comes with a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> !found_o)
    else $error("kvts_seq: table full reported on a hit");

  // a write never lands on a valid entry holding some other key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o.wr_entry |-> !valid_i[wr_addr_o])
    else $error("kvts_seq: new entry overwrites a valid entry");

endmodule

`default_nettype wire

// ===== bench/tb_key_value_table_store_core.sv =====
// tb_key_value_table_store_core: self-checking bench for the key-value table store
// depends on kvts_pkg and key_value_table_store_core; predicts every result beat
// from its own copy of the table and compares it field by field
`default_nettype none

module tb_key_value_table_store_core;
  import kvts_pkg::*;

  localparam int FW = KVTS_FIELD_BITS;
  localparam int CntW = $clog2(KVTS_ENTRIES + 1);

  // only the low key and value bits take part in the table
  localparam logic [FW-1:0] KEY_MASK =
    (KVTS_KEY_BITS >= FW) ? '1 : ((64'd1 << KVTS_KEY_BITS) - 64'd1);
  localparam logic [FW-1:0] VALUE_MASK =
    (KVTS_VALUE_BITS >= FW) ? '1 : ((64'd1 << KVTS_VALUE_BITS) - 64'd1);

  localparam int STALL_LIMIT = 1000;   // cycles without any beat before giving up
  localparam int RANDOM_ITEMS = 1130;  // stop growing the random part here
  localparam int QUIET_FROM = 450;     // stretch of sent items with no idling
  localparam int QUIET_TO = 650;

  typedef struct {
    logic [1:0]    command;
    logic [FW-1:0] key;
    logic [FW-1:0] value;
  } table_cmd_t;

  typedef struct {
    logic            found;
    logic [FW-1:0]   read_value;
    status_e         status;
    logic [CntW-1:0] entry_count;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] command_i = '0;
  logic [FW-1:0] key_i = '0;
  logic [FW-1:0] value_i = '0;

  wire busy_o;
  wire done_o;
  wire found_o;
  wire [FW-1:0] read_value_o;
  wire [1:0] status_o;
  wire [CntW-1:0] entry_count_o;

  key_value_table_store_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  // bench copy of the table, updated as each command beat is taken
  logic          table_valid [KVTS_ENTRIES];
  logic [FW-1:0] table_key   [KVTS_ENTRIES];
  logic [FW-1:0] table_value [KVTS_ENTRIES];
  int            table_count;

  table_cmd_t    pending_cmds[$];
  table_result_t expected_results[$];

  logic beat_taken = 1'b0;
  int   sent_count = 0;
  int   stall_cycles = 0;
  int   error_count = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // apply one command to the bench table and return the result it should give
  function automatic table_result_t apply_table_command(input logic [1:0] cmd,
                                                        input logic [FW-1:0] key_raw,
                                                        input logic [FW-1:0] val_raw);
    table_result_t r;
    logic [FW-1:0] key;
    logic [FW-1:0] val;
    int hit;
    int slot;
    key = key_raw & KEY_MASK;
    val = val_raw & VALUE_MASK;
    r.found = 1'b0;
    r.read_value = '0;
    r.status = ST_DONE;
    hit = -1;
    slot = -1;
    if (cmd != CMD_NOP) begin
      for (int i = 0; i < KVTS_ENTRIES; i++) begin
        if (hit < 0 && table_valid[i] && table_key[i] == key) hit = i;
        if (slot < 0 && !table_valid[i]) slot = i;
      end
      r.found = (hit >= 0);
      if (cmd == CMD_PUT) begin
        if (hit >= 0) begin
          table_value[hit] = val;
        end else if (slot >= 0) begin
          // unknown key lands in the lowest free entry
          table_valid[slot] = 1'b1;
          table_key[slot] = key;
          table_value[slot] = val;
          table_count++;
        end else begin
          r.status = ST_FULL;
        end
      end else if (hit < 0) begin
        r.status = ST_ABSENT;
      end else if (cmd == CMD_GET) begin
        r.read_value = table_value[hit];
      end else begin
        table_valid[hit] = 1'b0;
        table_count--;
      end
    end
    r.entry_count = table_count[CntW-1:0];
    return r;
  endfunction

  task automatic queue_command(input logic [1:0] cmd, input logic [FW-1:0] key,
                               input logic [FW-1:0] val);
    table_cmd_t c;
    c.command = cmd;
    c.key = key;
    c.value = val;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [FW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // driver: inputs move on the falling edge; a raised start holds until taken
  always @(negedge clk_i) begin : drive
    table_cmd_t nxt;
    logic quiet;
    quiet = (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !beat_taken) begin
      // beat still waiting for the block to go idle
    end else if (pending_cmds.size() == 0 || (!quiet && $urandom_range(0, 99) < 37)) begin
      start_i <= 1'b0;
    end else begin
      nxt = pending_cmds.pop_front();
      start_i <= 1'b1;
      command_i <= nxt.command;
      key_i <= nxt.key;
      value_i <= nxt.value;
      sent_count++;
    end
  end

  // monitor: sample both handshakes on the rising edge
  always @(posedge clk_i) begin : watch
    table_result_t exp_r;
    logic took;
    took = rst_ni && start_i && !busy_o;
    beat_taken <= took;
    if (took) begin
      expected_results.push_back(apply_table_command(command_i, key_i, value_i));
    end
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected (found %0b status %0d count %0d)",
                 $time, found_o, status_o, entry_count_o);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (found_o !== exp_r.found) begin
          $display("%0t: found expected %0b actual %0b", $time, exp_r.found, found_o);
          error_count++;
        end
        if (read_value_o !== exp_r.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, exp_r.read_value,
                   read_value_o);
          error_count++;
        end
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
          error_count++;
        end
        if (entry_count_o !== exp_r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.entry_count,
                   entry_count_o);
          error_count++;
        end
      end
    end
    stall_cycles <= (took || done_o) ? 0 : stall_cycles + 1;
  end

  // watchdog on cycles without any beat in either direction
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    logic [FW-1:0] pool[24];
    int pool_n;
    int phase_len;
    int roll;
    logic [FW-1:0] k;

    for (int i = 0; i < KVTS_ENTRIES; i++) begin
      table_valid[i] = 1'b0;
      table_key[i] = '0;
      table_value[i] = '0;
    end
    table_count = 0;

    // directed: lookups on an empty table, extreme keys and values, overwrite,
    // no-op code, delete of a missing key, then fill up and hit the full table
    queue_command(CMD_GET, '1, '0);
    queue_command(CMD_DEL, '0, '1);
    queue_command(CMD_PUT, '0, '1);
    queue_command(CMD_PUT, '1, '0);
    queue_command(CMD_PUT, '0, 64'ha5a5_5a5a_c3c3_3c3c);
    queue_command(CMD_GET, '0, '0);
    queue_command(CMD_GET, '1, '1);
    queue_command(CMD_NOP, '0, '1);
    queue_command(CMD_DEL, '0, '0);
    queue_command(CMD_DEL, '0, '0);
    for (int i = 1; i < KVTS_ENTRIES; i++) queue_command(CMD_PUT, FW'(i), rand_word());
    queue_command(CMD_PUT, 64'h8000_0000_0000_0000, rand_word());
    queue_command(CMD_PUT, '1, 64'h0123_4567_89ab_cdef);
    // empty the table again before the random part
    for (int i = 1; i < KVTS_ENTRIES; i++) queue_command(CMD_DEL, FW'(i), rand_word());
    queue_command(CMD_DEL, '1, rand_word());

    // random phases: each works a small pool of keys so gets and deletes hit,
    // pools over ENTRIES keys drive the table full, and each phase ends by
    // deleting its pool so the next one starts from a clean table
    while (pending_cmds.size() < RANDOM_ITEMS) begin
      pool_n = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(2, 20);
      for (int i = 0; i < pool_n; i++) pool[i] = rand_word();
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        k = pool[$urandom_range(0, pool_n - 1)];
        if (roll < 45) begin
          queue_command(CMD_PUT, k, rand_word());
        end else if (roll < 72) begin
          queue_command(CMD_GET, ($urandom_range(0, 9) == 0) ? rand_word() : k, rand_word());
        end else if (roll < 94) begin
          queue_command(CMD_DEL, ($urandom_range(0, 9) == 0) ? rand_word() : k, rand_word());
        end else begin
          queue_command(CMD_NOP, rand_word(), rand_word());
        end
      end
      for (int i = 0; i < pool_n; i++) queue_command(CMD_DEL, pool[i], rand_word());
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent, start dropped and every result back
    while (pending_cmds.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (KVTS_ENTRIES + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== key_value_table_store_core.f =====
sv/kvts_pkg.sv
sv/kvts_store.sv
sv/kvts_seq.sv
sv/key_value_table_store_core.sv
bench/tb_key_value_table_store_core.sv
